>>> rtl/mtg_pkg.sv
package mtg_pkg;

  // generator geometry
  localparam int WORD_W      = 32;
  localparam int STATE_DEPTH = 624;
  localparam int TAP_OFFSET  = 397;
  localparam int IDX_W       = 10;
  localparam int TAP_WRAP    = STATE_DEPTH - TAP_OFFSET;

  // request queue and result queue sizes
  localparam int REQ_DEPTH = 4;
  localparam int REQ_CNT_W = 3;
  localparam int OQ_DEPTH  = 4;
  localparam int OQ_PTR_W  = 2;
  localparam int OQ_CNT_W  = 3;

  // algorithm constants
  localparam logic [WORD_W-1:0] SEED_RESET = 32'd5489;
  localparam logic [WORD_W-1:0] XOR_MATRIX = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hEFC6_0000;
  localparam logic [WORD_W-1:0] INIT_MUL   = 32'd1812433253;

  // seed load command from the configuration port
  typedef struct packed {
    logic              load;
    logic [WORD_W-1:0] seed;
  } seed_cmd_t;

  // request hand-over between front and back
  typedef struct packed {
    logic valid;
    logic take;
  } req_link_t;

  // output tempering
  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
    logic [WORD_W-1:0] y;
    y = y_in ^ (y_in >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // one word of the twist recurrence
  function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] hi_src,
                                                   input logic [WORD_W-1:0] lo_src,
                                                   input logic [WORD_W-1:0] tap);
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] w;
    z = {hi_src[WORD_W-1], lo_src[WORD_W-2:0]};
    w = tap ^ (z >> 1);
    if (z[0]) begin
      w = w ^ XOR_MATRIX;
    end
    return w;
  endfunction

  // one step of the seeding recurrence, low word of the product only
  function automatic logic [WORD_W-1:0] init_step(input logic [WORD_W-1:0] prev,
                                                  input logic [IDX_W-1:0]  idx);
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] prod;
    mix  = prev ^ (prev >> 30);
    prod = INIT_MUL * mix;
    return prod + WORD_W'(idx);
  endfunction

endpackage

>>> rtl/mtg_ram.sv
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/mtg_front.sv
module mtg_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  flush,
  input  logic                  push,
  input  logic                  draw_request,
  output logic                  full,
  output logic                  req_valid,
  input  logic                  req_take
);

  logic [mtg_pkg::REQ_CNT_W-1:0] pend_cnt;
  logic [mtg_pkg::REQ_CNT_W-1:0] pend_cnt_next;
  logic                          accepted;
  logic                          is_draw;

  // accept a transaction and keep only real draw requests
  assign full      = (pend_cnt == mtg_pkg::REQ_CNT_W'(mtg_pkg::REQ_DEPTH));
  assign accepted  = push && !full;
  assign is_draw   = accepted && draw_request;
  assign req_valid = (pend_cnt != '0);

  always_comb begin
    pend_cnt_next = pend_cnt;
    if (is_draw) begin
      pend_cnt_next = pend_cnt_next + 1'b1;
    end
    if (req_take) begin
      pend_cnt_next = pend_cnt_next - 1'b1;
    end
  end

  // pending request count
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      pend_cnt <= '0;
    end else begin
      pend_cnt <= pend_cnt_next;
    end
  end

endmodule

>>> rtl/mtg_back.sv
module mtg_back (
  input  logic                         clk,
  input  logic                         rst,
  input  mtg_pkg::seed_cmd_t           cmd,
  input  logic                         req_valid,
  output logic                         req_take,
  input  logic [mtg_pkg::OQ_CNT_W-1:0] oq_count,
  output logic                         out_valid,
  output logic [mtg_pkg::WORD_W-1:0]   out_word
);

  localparam logic [mtg_pkg::IDX_W-1:0] LAST_IDX =
    mtg_pkg::IDX_W'(mtg_pkg::STATE_DEPTH - 1);
  localparam logic [mtg_pkg::IDX_W-1:0] TAP_IDX =
    mtg_pkg::IDX_W'(mtg_pkg::TAP_OFFSET);
  localparam logic [mtg_pkg::IDX_W-1:0] WRAP_IDX =
    mtg_pkg::IDX_W'(mtg_pkg::TAP_WRAP);

  // seeding pass
  logic                        filling;
  logic [mtg_pkg::IDX_W-1:0]   fill_idx;
  logic [mtg_pkg::WORD_W-1:0]  fill_word;
  logic [mtg_pkg::IDX_W-1:0]   fill_idx_inc;

  // twist pipeline
  logic [mtg_pkg::IDX_W-1:0]   twist_idx;
  logic [mtg_pkg::IDX_W-1:0]   twist_idx_next;
  logic [mtg_pkg::IDX_W-1:0]   tap_addr;
  logic [mtg_pkg::WORD_W-1:0]  cur_word;
  logic                        s2_valid;
  logic [mtg_pkg::IDX_W-1:0]   s2_idx;
  logic                        room;
  logic                        issue;

  // memory ports
  logic                        wr_en;
  logic [mtg_pkg::IDX_W-1:0]   wr_addr;
  logic [mtg_pkg::WORD_W-1:0]  wr_data;
  logic [mtg_pkg::WORD_W-1:0]  nxt_word;
  logic [mtg_pkg::WORD_W-1:0]  tap_word;
  logic [mtg_pkg::WORD_W-1:0]  new_word;

  // issue when no seeding pass runs, a request waits and the result queue can take it
  assign room = s2_valid ? (oq_count < mtg_pkg::OQ_CNT_W'(mtg_pkg::OQ_DEPTH - 1))
                         : (oq_count < mtg_pkg::OQ_CNT_W'(mtg_pkg::OQ_DEPTH));
  assign issue    = !filling && req_valid && room;
  assign req_take = issue;

  // neighbour and tap addresses of the word being twisted
  assign twist_idx_next = (twist_idx == LAST_IDX) ? '0 : twist_idx + 1'b1;
  assign tap_addr = (twist_idx < WRAP_IDX) ? twist_idx + TAP_IDX : twist_idx - WRAP_IDX;

  // twist and temper once the reads return
  assign new_word  = mtg_pkg::twist_word(cur_word, nxt_word, tap_word);
  assign out_valid = s2_valid;
  assign out_word  = mtg_pkg::temper(new_word);

  // shared write port: seeding pass or twisted word
  assign fill_idx_inc = fill_idx + 1'b1;
  assign wr_en   = filling || s2_valid;
  assign wr_addr = filling ? fill_idx : s2_idx;
  assign wr_data = filling ? fill_word : new_word;

  // copy holding the neighbour words
  mtg_ram #(
    .WIDTH(mtg_pkg::WORD_W),
    .DEPTH(mtg_pkg::STATE_DEPTH)
  ) u_ram_nxt (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (issue),
    .rd_addr(twist_idx_next),
    .rd_data(nxt_word)
  );

  // copy holding the tap words
  mtg_ram #(
    .WIDTH(mtg_pkg::WORD_W),
    .DEPTH(mtg_pkg::STATE_DEPTH)
  ) u_ram_tap (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (issue),
    .rd_addr(tap_addr),
    .rd_data(tap_word)
  );

  // seeding pass, twist index and pipeline stage
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      filling   <= 1'b1;
      fill_idx  <= '0;
      fill_word <= rst ? mtg_pkg::SEED_RESET : cmd.seed;
      cur_word  <= rst ? mtg_pkg::SEED_RESET : cmd.seed;
      twist_idx <= '0;
      s2_valid  <= 1'b0;
      s2_idx    <= '0;
    end else begin
      if (filling) begin
        fill_idx  <= fill_idx_inc;
        fill_word <= mtg_pkg::init_step(fill_word, fill_idx_inc);
        if (fill_idx == LAST_IDX) begin
          filling <= 1'b0;
        end
      end
      s2_valid <= issue;
      if (issue) begin
        s2_idx    <= twist_idx;
        twist_idx <= twist_idx_next;
      end
      if (s2_valid) begin
        cur_word <= nxt_word;
      end
    end
  end

endmodule

>>> rtl/mtg_outq.sv
module mtg_outq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         flush,
  input  logic                         in_valid,
  input  logic [mtg_pkg::WORD_W-1:0]   in_word,
  output logic [mtg_pkg::OQ_CNT_W-1:0] count,
  output logic                         empty,
  input  logic                         pop,
  output logic [mtg_pkg::WORD_W-1:0]   random_word
);

  logic [mtg_pkg::WORD_W-1:0]   slots [mtg_pkg::OQ_DEPTH];
  logic [mtg_pkg::OQ_PTR_W-1:0] wr_ptr;
  logic [mtg_pkg::OQ_PTR_W-1:0] rd_ptr;
  logic                         do_pop;

  assign empty       = (count == '0);
  assign do_pop      = pop && !empty;
  assign random_word = slots[rd_ptr];

  // result storage
  always_ff @(posedge clk) begin
    if (in_valid) begin
      slots[wr_ptr] <= in_word;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (in_valid && !do_pop) begin
        count <= count + 1'b1;
      end else if (!in_valid && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/mersenne_twister_generator.sv
// 32-bit mt19937 random word generator behind two queue-style channels.
// draw side: hold push with draw_request; a transaction completes at a
//   rising edge with push high and full low. draw_request low is taken
//   and dropped without a result.
// result side: while empty is low random_word holds the oldest word; it
//   is taken at a rising edge with pop high.
// seed side: cfg_valid/cfg_ready with seed; cfg_ready is always high.
//   a seed write flushes waiting requests and results and reseeds.
// a draw passes the request count, memory read stage and result queue.
//   throughput is one word per cycle when not seeding and the result
//   queue has room; the two-copy state memory twists one word per draw.
// reset and every seed write start a seeding pass over all 624 words of
//   the state memory (one multiply-add per word); up to four draws queue
//   up meanwhile and are served once the pass ends.
// when pop stays low the four-entry result queue fills, generation
//   pauses, then the four-entry request queue fills and full rises.
module mersenne_twister_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        draw_request,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] random_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] seed
);

  mtg_pkg::seed_cmd_t           cmd;
  mtg_pkg::req_link_t           req;
  logic [mtg_pkg::OQ_CNT_W-1:0] oq_count;
  logic                         gen_valid;
  logic [mtg_pkg::WORD_W-1:0]   gen_word;

  // seed write decode
  assign cfg_ready = 1'b1;
  assign cmd.load  = cfg_valid && cfg_ready;
  assign cmd.seed  = seed;

  // request intake
  mtg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .flush       (cmd.load),
    .push        (push),
    .draw_request(draw_request),
    .full        (full),
    .req_valid   (req.valid),
    .req_take    (req.take)
  );

  // seeding and twist engine
  mtg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req_valid(req.valid),
    .req_take (req.take),
    .oq_count (oq_count),
    .out_valid(gen_valid),
    .out_word (gen_word)
  );

  // result queue
  mtg_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .flush      (cmd.load),
    .in_valid   (gen_valid),
    .in_word    (gen_word),
    .count      (oq_count),
    .empty      (empty),
    .pop        (pop),
    .random_word(random_word)
  );

  // result queue never written beyond its depth
  assert property (@(posedge clk) disable iff (rst)
    gen_valid |-> (oq_count < mtg_pkg::OQ_CNT_W'(mtg_pkg::OQ_DEPTH)))
    else $error("result queue overflow");

  // engine takes a request only when one is pending
  assert property (@(posedge clk) disable iff (rst)
    req.take |-> req.valid)
    else $error("request taken from empty queue");

  // a seed write leaves no stale result behind
  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> empty)
    else $error("result left after seed write");

endmodule
